// File: hw/rtl/room_slot_cache_unit_assert.svh
// Assertion macros shared by the room slot cache checker.
`ifndef ROOM_SLOT_CACHE_UNIT_ASSERT_SVH
`define ROOM_SLOT_CACHE_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/rsc_pkg.sv
// Shared constants and types of the room slot cache.
package rsc_pkg;

	localparam int SLOTS  = 32;
	localparam int ROOMS  = 256;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ROOM_W = $clog2(ROOMS);
	localparam int CNT_W  = 6;

	typedef enum logic [1:0] {
		CMD_TOUCH    = 2'd0,
		CMD_FREE     = 2'd1,
		CMD_SET_BASE = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

// File: hw/rtl/rsc_if.sv
// Channel interfaces of the room slot cache: request, response, configuration.
interface rsc_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 command;
	logic [rsc_pkg::ROOM_W-1:0] room;
	logic [rsc_pkg::SLOT_W-1:0] slot;

	modport source(output valid, command, room, slot, input ready);
	modport sink(input valid, command, room, slot, output ready);
endinterface

interface rsc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rsc_pkg::SLOT_W-1:0] slot_out;
	logic                       refill;

	modport source(output valid, slot_out, refill, input ready);
	modport sink(input valid, slot_out, refill, output ready);
endinterface

interface rsc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [rsc_pkg::CNT_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// File: hw/rtl/rsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/rsc_ctrl.sv
// Controller of the room slot cache: capture an item, then execute it.
module rsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rsc_pkg::dp_status_t status,
	output rsc_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	// Decode commands for the datapath
	always_comb begin
		cmd.capture = req_valid && ready_q;
		cmd.exec    = (state_q == ST_EXEC) && !status.out_busy;
	end

	assign req_ready = ready_q;

	// Hold state and the ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
						ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/rsc_dp.sv
// Datapath of the room slot cache: link table, slot tables and result register.
module rsc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 req_command,
	input  logic [rsc_pkg::ROOM_W-1:0] req_room,
	input  logic [rsc_pkg::SLOT_W-1:0] req_slot,
	input  logic                       cfg_valid,
	input  logic [rsc_pkg::CNT_W-1:0]  cfg_data,
	input  rsc_pkg::ctrl_cmd_t         cmd,
	output rsc_pkg::dp_status_t        status,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [rsc_pkg::SLOT_W-1:0] rsp_slot_out,
	output logic                       rsp_refill
);

	// Captured item
	rsc_pkg::cmd_t              cmd_q;
	logic [rsc_pkg::ROOM_W-1:0] room_q;
	logic [rsc_pkg::SLOT_W-1:0] slot_q;

	// Room to slot links: valid flags in flops, slot index in RAM
	logic [rsc_pkg::ROOMS-1:0]  link_valid_q;
	logic [rsc_pkg::SLOT_W-1:0] link_slot;
	logic                       link_we;

	// Per-slot state
	logic [rsc_pkg::SLOTS-1:0]  owner_valid_q;
	logic [rsc_pkg::ROOM_W-1:0] owner_room_q [rsc_pkg::SLOTS];
	logic [rsc_pkg::SLOTS-1:0]  base_valid_q;
	logic [rsc_pkg::ROOM_W-1:0] base_room_q [rsc_pkg::SLOTS];
	logic [rsc_pkg::SLOTS-1:0]  aged_q;

	logic                       cur_base_valid_q;
	logic [rsc_pkg::ROOM_W-1:0] cur_base_q;
	logic [rsc_pkg::CNT_W-1:0]  slots_in_use_q;

	// Result register
	logic                       out_valid_q;
	logic [rsc_pkg::SLOT_W-1:0] slot_out_q;
	logic                       refill_q;

	// Execute-cycle decode
	logic                       is_touch;
	logic                       link_hit;
	logic                       tag_eq;
	logic                       hit;
	logic [rsc_pkg::CNT_W-1:0]  search_len;
	logic [rsc_pkg::SLOTS-1:0]  search_mask;
	logic [rsc_pkg::SLOTS-1:0]  free_vec;
	logic [rsc_pkg::SLOTS-1:0]  first_free;
	logic [rsc_pkg::SLOT_W-1:0] pick;
	logic [rsc_pkg::SLOT_W-1:0] result_slot;
	logic [rsc_pkg::SLOTS-1:0]  owner_next;

	rsc_ram #(
		.WIDTH(rsc_pkg::SLOT_W),
		.DEPTH(rsc_pkg::ROOMS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(room_q),
		.wdata(pick),
		.re   (cmd.capture),
		.raddr(req_room),
		.rdata(link_slot)
	);

	// Compare the current base against the linked slot's base
	always_comb begin
		is_touch = (cmd_q == rsc_pkg::CMD_TOUCH);
		link_hit = link_valid_q[room_q];
		tag_eq   = (cur_base_valid_q == base_valid_q[link_slot]) &&
		           (!cur_base_valid_q || (cur_base_q == base_room_q[link_slot]));
		hit      = link_hit && tag_eq;
		link_we  = cmd.exec && is_touch && !hit;
	end

	// Find the first free slot within the search length, else slot 0
	always_comb begin
		search_len = (slots_in_use_q > rsc_pkg::CNT_W'(rsc_pkg::SLOTS)) ?
		             rsc_pkg::CNT_W'(rsc_pkg::SLOTS) : slots_in_use_q;
		for (int i = 0; i < rsc_pkg::SLOTS; i++) begin
			search_mask[i] = rsc_pkg::CNT_W'(i) < search_len;
		end
		free_vec   = aged_q & search_mask;
		first_free = free_vec & (~free_vec + rsc_pkg::SLOTS'(1));
		pick       = '0;
		for (int i = 0; i < rsc_pkg::SLOTS; i++) begin
			pick = pick | (first_free[i] ? rsc_pkg::SLOT_W'(i) : '0);
		end
	end

	// Drop the old owner of a relinked room, then take the picked slot
	always_comb begin
		owner_next = owner_valid_q;
		if (link_hit) begin
			owner_next[link_slot] = 1'b0;
		end
		owner_next[pick] = 1'b1;
	end

	always_comb begin
		if (!is_touch) begin
			result_slot = slot_q;
		end else if (hit) begin
			result_slot = link_slot;
		end else begin
			result_slot = pick;
		end
	end

	assign status.out_busy = out_valid_q && !rsp_ready;

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= rsc_pkg::cmd_t'(req_command);
			room_q <= req_room;
			slot_q <= req_slot;
		end
	end

	// Update slot and link state on execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_valid_q     <= '0;
			owner_valid_q    <= '0;
			base_valid_q     <= '0;
			aged_q           <= '1;
			cur_base_valid_q <= 1'b0;
			slots_in_use_q   <= '0;
		end else begin
			if (cfg_valid) begin
				slots_in_use_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (cmd_q)
					rsc_pkg::CMD_TOUCH: begin
						if (hit) begin
							aged_q[link_slot] <= 1'b0;
						end else begin
							link_valid_q[room_q] <= 1'b1;
							owner_valid_q        <= owner_next;
							aged_q[pick]         <= 1'b0;
							base_valid_q[pick]   <= cur_base_valid_q;
						end
					end
					rsc_pkg::CMD_FREE: begin
						if (owner_valid_q[slot_q]) begin
							link_valid_q[owner_room_q[slot_q]] <= 1'b0;
						end
						owner_valid_q[slot_q] <= 1'b0;
						base_valid_q[slot_q]  <= 1'b0;
						aged_q[slot_q]        <= 1'b1;
					end
					rsc_pkg::CMD_SET_BASE: begin
						cur_base_valid_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Update slot payload fields, which are qualified by their valid flags
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_touch && !hit) begin
				owner_room_q[pick] <= room_q;
				base_room_q[pick]  <= cur_base_q;
			end
			if (cmd_q == rsc_pkg::CMD_SET_BASE) begin
				cur_base_q <= room_q;
			end
		end
	end

	// Hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			slot_out_q <= result_slot;
			refill_q   <= is_touch && !hit;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign rsp_slot_out = slot_out_q;
	assign rsp_refill   = refill_q;

endmodule

// File: hw/rtl/room_slot_cache_unit.sv
// Top level of the room slot cache.
// Usage:
//   req carries one command per transfer: touch a room, free a slot, or set
//   the current base room. rsp returns one result per request: the slot of a
//   touched room (or the echoed slot) and a refill flag that asks for the
//   slot's contents to be rebuilt. cfg writes slots_in_use, the number of
//   slots searched for a free one; write it only while the unit is idle.
// Timing:
//   A request is captured in its transfer cycle, which also reads the room link
//   RAM; the execute state then resolves hit or miss, updates the tables and
//   loads the result register, waiting while that register still holds a result.
//   The result and req.ready are both registered at the end of execute, so a
//   new request is taken only once the last one has executed.
// Reset:
//   All rooms unlinked, all slots free, no base room, slots_in_use zero.
//   Valid flags clear at once, so there is no clearing pass.
// Backpressure:
//   The result register holds while rsp.ready is low; the next request is
//   still captured and waits in its execute cycle until the register drains.
module room_slot_cache_unit (
	input logic      clk,
	input logic      arst_n,
	rsc_req_if.sink  req,
	rsc_rsp_if.source rsp,
	rsc_cfg_if.sink  cfg
);

	rsc_pkg::ctrl_cmd_t  ctrl_cmd;
	rsc_pkg::dp_status_t dp_status;

	assign cfg.ready = 1'b1;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.status   (dp_status),
		.cmd      (ctrl_cmd)
	);

	rsc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_command (req.command),
		.req_room    (req.room),
		.req_slot    (req.slot),
		.cfg_valid   (cfg.valid),
		.cfg_data    (cfg.data),
		.cmd         (ctrl_cmd),
		.status      (dp_status),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_slot_out(rsp.slot_out),
		.rsp_refill  (rsp.refill)
	);

endmodule

// File: hw/rtl/rsc_checker.sv
// Port-level checker of the room slot cache and its bind to the top level.
`include "room_slot_cache_unit_assert.svh"

module rsc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [rsc_pkg::SLOT_W-1:0] rsp_slot_out,
	input logic                       rsp_refill
);

	// Hold a stalled result
	`RSC_ASSERT_NEXT(a_rsp_hold_valid, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`RSC_ASSERT_NEXT(a_rsp_hold_data, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_slot_out) && $stable(rsp_refill))

	// Drop ready for the execute cycle after a request transfer
	`RSC_ASSERT_NEXT(a_req_busy, clk, arst_n, req_valid && req_ready, !req_ready)

	// Raise a result only after a request transfer
	`RSC_ASSERT_NOW(a_rsp_after_req, clk, arst_n, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind room_slot_cache_unit rsc_checker u_rsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_slot_out(rsp.slot_out),
	.rsp_refill  (rsp.refill)
);
